// ----- hdl/lvc_pkg.sv -----
`timescale 1ns / 1ps
// shared widths, light kind codes and packing constants for the light volume cull test
// no dependencies

package lvc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIR_BITS    = 16;
    localparam int SCALAR_BITS = 16;
    localparam int VEC_BITS    = 3 * COORD_BITS;
    localparam int DIRV_BITS   = 3 * DIR_BITS;

    // corner or center difference, signed
    localparam int VB   = COORD_BITS + 1;
    // squared magnitude of one difference component
    localparam int SQB  = 2 * VB - 1;
    // squared length of a difference vector
    localparam int LB   = SQB + 2;
    // one product of direction and difference, signed
    localparam int PB   = DIR_BITS + VB;
    // dot product, signed
    localparam int SB   = PB + 2;
    // split point for partial products
    localparam int LOB  = 18;
    localparam int SHB  = SB - LOB;
    localparam int LHB  = LB - LOB;
    // squared outer cosine
    localparam int OB   = 2 * SCALAR_BITS - 1;
    // range squared
    localparam int R2B  = 2 * SCALAR_BITS;
    // reach is range plus radius
    localparam int RCB  = SCALAR_BITS + 1;
    localparam int RC2B = 2 * RCB;
    // width of the exact cone compare
    localparam int CW   = (2 * SB > OB + LB) ? 2 * SB : OB + LB;

    localparam int NSTAGE = 7;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = VEC_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BOX_MIN   = 2'd0,
        REG_BOX_MAX   = 2'd1,
        REG_CENTER    = 2'd2,
        REG_RADIUS    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_DIR   = 2'd0,
        KIND_POINT = 2'd1,
        KIND_SPOT  = 2'd2,
        KIND_OTHER = 2'd3
    } light_kind_t;

    localparam int IN_DATA_BITS  = 144;
    localparam int IN_USER_BITS  = 3;
    localparam int OUT_DATA_BITS = 24;

    function automatic logic [VB-1:0] coord_diff(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
        logic signed [VB-1:0] sa;
        logic signed [VB-1:0] sb;
        sa = VB'($signed(a));
        sb = VB'($signed(b));
        return sa - sb;
    endfunction

    function automatic logic [SQB-1:0] square_mag(input logic [VB-1:0] v);
        logic signed [2*VB-1:0] p;
        p = $signed(v) * $signed(v);
        return p[SQB-1:0];
    endfunction

endpackage

// ----- hdl/light_volume_cull_test_top.sv -----
`timescale 1ns / 1ps
// light volume cull test, top level: config registers, point test, eight corner lanes
// depends on lvc_pkg and lvc_corner
//
// lights arrive on the s_ channel, one transfer per light; each light gives exactly
// one result transfer on the m_ channel with its tag and the keep flag, in order.
// the config channel (cfg_valid, cfg_index, cfg_data) is always ready and writes
// box min, box max, sphere center and sphere radius; write it only while idle.
// a transfer loads the input register, then five arithmetic stages and the output
// register follow before m_tvalid.
// one light can enter every cycle while s_tready is high; the eight corner lanes
// do their squared compares through a pipeline.
// each stage has its own valid bit and advances when the stage after it is empty
// or moving, so bubbles close up while the receiver stalls; s_tready falls only
// when every stage holds a light. reset clears all valid bits and zeroes the
// config registers.

module light_volume_cull_test_top
    import lvc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // light_tag, light_position, light_range, light_direction, outer_cosine
    input  logic [IN_DATA_BITS-1:0]     s_tdata,
    // light_on, light_kind
    input  logic [IN_USER_BITS-1:0]     s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // result_tag, keep_light, zero fill
    output logic [OUT_DATA_BITS-1:0]    m_tdata
);

    logic [VEC_BITS-1:0]     box_min_reg;
    logic [VEC_BITS-1:0]     box_max_reg;
    logic [VEC_BITS-1:0]     center_reg;
    logic [SCALAR_BITS-1:0]  radius_reg;

    logic [NSTAGE-1:0]       v_reg;
    logic [NSTAGE-1:0]       v_next;
    logic [NSTAGE-1:0]       en;

    logic [15:0]             tag_reg [NSTAGE];
    logic                    on_reg [NSTAGE-1];
    light_kind_t             kind_reg [NSTAGE-1];

    logic [VEC_BITS-1:0]     pos0_reg;
    logic [SCALAR_BITS-1:0]  range0_reg;
    logic [DIRV_BITS-1:0]    dir0_reg;
    logic [SCALAR_BITS-1:0]  outer0_reg;

    logic [SCALAR_BITS-1:0]  range1_reg;
    logic [DIRV_BITS-1:0]    dir1_reg;
    logic [SCALAR_BITS-1:0]  outer1_reg;
    logic [VB-1:0]           pd1_reg [3];
    logic [RCB-1:0]          reach1_reg;

    logic [R2B-1:0]          r2_2_reg;
    logic [OB-1:0]           o2_2_reg;
    logic                    oneg2_reg;
    logic [SQB-1:0]          pdsq2_reg [3];
    logic [RC2B-1:0]         reach2_reg;

    logic [R2B-1:0]          r2_3_reg;
    logic [OB-1:0]           o2_3_reg;
    logic                    oneg3_reg;
    logic [LB-1:0]           pd2_3_reg;
    logic [RC2B-1:0]         reach2_3_reg;

    logic                    ptk_reg [2];
    logic                    keep_reg;

    logic [7:0]              c_range;
    logic [7:0]              c_cone;
    logic                    keep_next;
    logic signed [2*SCALAR_BITS-1:0] osq;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= '0;
            box_max_reg <= '0;
            center_reg  <= '0;
            radius_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOX_MIN: box_min_reg <= cfg_data;
                REG_BOX_MAX: box_max_reg <= cfg_data;
                REG_CENTER:  center_reg  <= cfg_data;
                REG_RADIUS:  radius_reg  <= cfg_data[SCALAR_BITS-1:0];
                default:     radius_reg  <= radius_reg;
            endcase
        end
    end

    always_comb
    begin
        en[NSTAGE-1] = !v_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        for (int k = 0; k < NSTAGE; k++)
        begin
            if (en[k])
            begin
                v_next[k] = (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];

    assign osq = $signed(outer1_reg) * $signed(outer1_reg);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tag_reg[0]  <= s_tdata[15:0];
            pos0_reg    <= s_tdata[63:16];
            range0_reg  <= s_tdata[79:64];
            dir0_reg    <= s_tdata[127:80];
            outer0_reg  <= s_tdata[143:128];
            on_reg[0]   <= s_tuser[0];
            kind_reg[0] <= light_kind_t'(s_tuser[2:1]);
        end
        for (int k = 1; k < NSTAGE - 1; k++)
        begin
            if (en[k])
            begin
                tag_reg[k]  <= tag_reg[k-1];
                on_reg[k]   <= on_reg[k-1];
                kind_reg[k] <= kind_reg[k-1];
            end
        end
        if (en[1])
        begin
            range1_reg <= range0_reg;
            dir1_reg   <= dir0_reg;
            outer1_reg <= outer0_reg;
            reach1_reg <= RCB'(range0_reg) + RCB'(radius_reg);
            for (int i = 0; i < 3; i++)
            begin
                pd1_reg[i] <= coord_diff(pos0_reg[i*COORD_BITS +: COORD_BITS],
                                         center_reg[i*COORD_BITS +: COORD_BITS]);
            end
        end
        if (en[2])
        begin
            r2_2_reg   <= range1_reg * range1_reg;
            o2_2_reg   <= osq[OB-1:0];
            oneg2_reg  <= outer1_reg[SCALAR_BITS-1];
            reach2_reg <= reach1_reg * reach1_reg;
            for (int i = 0; i < 3; i++)
            begin
                pdsq2_reg[i] <= square_mag(pd1_reg[i]);
            end
        end
        if (en[3])
        begin
            r2_3_reg     <= r2_2_reg;
            o2_3_reg     <= o2_2_reg;
            oneg3_reg    <= oneg2_reg;
            reach2_3_reg <= reach2_reg;
            pd2_3_reg    <= LB'(pdsq2_reg[0]) + LB'(pdsq2_reg[1]) + LB'(pdsq2_reg[2]);
        end
        if (en[4])
        begin
            ptk_reg[0] <= pd2_3_reg < LB'(reach2_3_reg);
        end
        if (en[5])
        begin
            ptk_reg[1] <= ptk_reg[0];
        end
        if (en[6])
        begin
            tag_reg[6] <= tag_reg[5];
            keep_reg   <= keep_next;
        end
    end

    genvar gk;
    generate
        for (gk = 0; gk < 8; gk++)
        begin : g_corner
            logic [VEC_BITS-1:0] corner;
            for (genvar gi = 0; gi < 3; gi++)
            begin : g_axis
                assign corner[gi*COORD_BITS +: COORD_BITS] = ((gk >> gi) & 1) != 0
                    ? box_max_reg[gi*COORD_BITS +: COORD_BITS]
                    : box_min_reg[gi*COORD_BITS +: COORD_BITS];
            end
            lvc_corner u_corner (
                .clk         (clk),
                .en          (en),
                .corner      (corner),
                .pos0        (pos0_reg),
                .dir1        (dir1_reg),
                .r2_3        (r2_3_reg),
                .o2_3        (o2_3_reg),
                .outer_neg_3 (oneg3_reg),
                .in_range    (c_range[gk]),
                .in_cone     (c_cone[gk])
            );
        end
    endgenerate

    always_comb
    begin
        keep_next = 1'b0;
        if (on_reg[5])
        begin
            case (kind_reg[5])
                KIND_DIR:   keep_next = 1'b1;
                KIND_POINT: keep_next = ptk_reg[1];
                KIND_SPOT:  keep_next = (|c_range) && (|c_cone);
                default:    keep_next = 1'b0;
            endcase
        end
    end

    assign m_tvalid = v_reg[NSTAGE-1];
    assign m_tdata  = {7'd0, keep_reg, tag_reg[6]};

    ast_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&v_reg))
        else $error("input blocked with an empty stage");

    ast_dir_kept: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] && en[6] && on_reg[5] && kind_reg[5] == KIND_DIR |=> m_tvalid && m_tdata[16])
        else $error("directional light not kept");

    ast_off_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[5] && en[6] && !on_reg[5] |=> m_tvalid && !m_tdata[16])
        else $error("switched off light kept");

endmodule

// ----- hdl/lvc_corner.sv -----
`timescale 1ns / 1ps
// one box corner lane: range test and exact cone test, five register stages
// depends on lvc_pkg

module lvc_corner
    import lvc_pkg::*;
(
    input  logic                   clk,
    input  logic [NSTAGE-1:0]      en,
    input  logic [VEC_BITS-1:0]    corner,
    input  logic [VEC_BITS-1:0]    pos0,
    input  logic [DIRV_BITS-1:0]   dir1,
    input  logic [R2B-1:0]         r2_3,
    input  logic [OB-1:0]          o2_3,
    input  logic                   outer_neg_3,
    output logic                   in_range,
    output logic                   in_cone
);

    logic [VB-1:0]          v_reg [3];
    logic [SQB-1:0]         sq_reg [3];
    logic [PB-1:0]          prod_reg [3];
    logic [LB-1:0]          len2_reg;
    logic signed [SB-1:0]   dot_reg;
    logic [2*SHB-1:0]       hh_reg;
    logic [SB-1:0]          hl_reg;
    logic [2*LOB-1:0]       ll_reg;
    logic [OB+LHB-1:0]      ohi_reg;
    logic [OB+LOB-1:0]      olo_reg;
    logic                   range4_reg;
    logic                   sneg_reg;
    logic                   lzero_reg;
    logic                   oneg_reg;
    logic                   range5_reg;
    logic                   cone5_reg;

    logic [SB-1:0]          smag;
    logic [CW-1:0]          s2;
    logic [CW-1:0]          o2l;
    logic                   cone_next;
    logic                   gt;
    logic                   lt;

    assign smag = dot_reg[SB-1] ? SB'(-dot_reg) : SB'(dot_reg);

    assign s2  = (CW'(hh_reg) << (2 * LOB)) + (CW'(hl_reg) << (LOB + 1)) + CW'(ll_reg);
    assign o2l = (CW'(ohi_reg) << LOB) + CW'(olo_reg);
    assign gt  = s2 > o2l;
    assign lt  = s2 < o2l;

    always_comb
    begin
        if (lzero_reg)
        begin
            cone_next = oneg_reg;
        end
        else if (!sneg_reg && oneg_reg)
        begin
            cone_next = 1'b1;
        end
        else if (sneg_reg && !oneg_reg)
        begin
            cone_next = 1'b0;
        end
        else if (!sneg_reg)
        begin
            cone_next = gt;
        end
        else
        begin
            cone_next = lt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i] <= coord_diff(corner[i*COORD_BITS +: COORD_BITS],
                                       pos0[i*COORD_BITS +: COORD_BITS]);
            end
        end
        if (en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]   <= square_mag(v_reg[i]);
                prod_reg[i] <= $signed(dir1[i*DIR_BITS +: DIR_BITS]) * $signed(v_reg[i]);
            end
        end
        if (en[3])
        begin
            len2_reg <= LB'(sq_reg[0]) + LB'(sq_reg[1]) + LB'(sq_reg[2]);
            dot_reg  <= SB'($signed(prod_reg[0])) + SB'($signed(prod_reg[1]))
                        + SB'($signed(prod_reg[2]));
        end
        if (en[4])
        begin
            hh_reg     <= smag[SB-1:LOB] * smag[SB-1:LOB];
            hl_reg     <= smag[SB-1:LOB] * smag[LOB-1:0];
            ll_reg     <= smag[LOB-1:0] * smag[LOB-1:0];
            ohi_reg    <= o2_3 * len2_reg[LB-1:LOB];
            olo_reg    <= o2_3 * len2_reg[LOB-1:0];
            range4_reg <= len2_reg < LB'(r2_3);
            sneg_reg   <= dot_reg[SB-1];
            lzero_reg  <= len2_reg == '0;
            oneg_reg   <= outer_neg_3;
        end
        if (en[5])
        begin
            range5_reg <= range4_reg;
            cone5_reg  <= cone_next;
        end
    end

    assign in_range = range5_reg;
    assign in_cone  = cone5_reg;

endmodule
